@@ rtl/core/b64e_pkg.sv @@
// b64e_pkg: shared types, constants and the sextet-to-ascii mapping
// for the base64 stream encoder; no dependencies
package b64e_pkg;

    localparam int CHAR_W   = 7;
    localparam int SEXTET_W = 6;
    localparam int MAX_CHARS = 4;
    localparam int IDX_W    = 2;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    // one queue entry: the characters a single input byte produces
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [IDX_W-1:0]                 last_idx;
        logic                             last;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
        logic [CHAR_W-1:0] r;
        if (v < 6'd26) begin
            r = 7'd65 + {1'b0, v};
        end else if (v < 6'd52) begin
            r = 7'd71 + {1'b0, v};
        end else if (v < 6'd62) begin
            r = {1'b0, v} - 7'd4;
        end else if (v == 6'd62) begin
            r = 7'd43;
        end else begin
            r = 7'd47;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/b64e_front.sv @@
// b64e_front: accepts raw bytes, tracks group phase and leftover bits,
// and builds one character command per byte; uses b64e_pkg
module b64e_front import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    input  t_q_status  i_q_status,
    output logic       o_stall,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_leftover, n_leftover;
    logic       accept;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;
    assign o_push  = accept;

    always_comb begin
        n_phase    = r_phase;
        n_leftover = r_leftover;
        o_cmd      = '0;
        o_cmd.last = i_end_of_message;
        case (r_phase)
            PH_SECOND: begin
                o_cmd.chars[0] = sextet_char({r_leftover[1:0], i_data_byte[7:4]});
                o_cmd.chars[1] = sextet_char({i_data_byte[3:0], 2'b00});
                o_cmd.chars[2] = PAD_CHAR;
                o_cmd.last_idx = i_end_of_message ? 2'd2 : 2'd0;
                n_leftover     = i_data_byte[3:0];
                n_phase        = PH_THIRD;
            end
            PH_THIRD: begin
                o_cmd.chars[0] = sextet_char({r_leftover, i_data_byte[7:6]});
                o_cmd.chars[1] = sextet_char(i_data_byte[5:0]);
                o_cmd.last_idx = 2'd1;
                n_leftover     = 4'd0;
                n_phase        = PH_FIRST;
            end
            default: begin
                o_cmd.chars[0] = sextet_char(i_data_byte[7:2]);
                o_cmd.chars[1] = sextet_char({i_data_byte[1:0], 4'b0000});
                o_cmd.chars[2] = PAD_CHAR;
                o_cmd.chars[3] = PAD_CHAR;
                o_cmd.last_idx = i_end_of_message ? 2'd3 : 2'd0;
                n_leftover     = {2'b00, i_data_byte[1:0]};
                n_phase        = PH_SECOND;
            end
        endcase
        // message end always restarts the group
        if (i_end_of_message) begin
            n_phase    = PH_FIRST;
            n_leftover = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_leftover <= 4'd0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_leftover <= n_leftover;
        end
    end

endmodule

@@ rtl/core/b64e_queue.sv @@
// b64e_queue: small register queue of character commands between
// front and back; uses b64e_pkg
module b64e_queue import b64e_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue pop while empty");

endmodule

@@ rtl/core/b64e_back.sv @@
// b64e_back: walks the head command one character a cycle into the
// output register while the receiver does not stall; uses b64e_pkg
module b64e_back import b64e_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_head,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_final_char
);

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_final;
    logic              load;
    logic              at_end;

    assign load   = !i_q_status.empty && (!r_out_valid || !i_stall);
    assign at_end = (r_idx == i_head.last_idx);
    assign o_pop  = load && at_end;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = at_end ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char  <= i_head.chars[r_idx];
            r_out_final <= i_head.last && at_end;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_char   = r_out_char;
    assign o_final_char = r_out_final;

    // a partly sent command stays at the head until its last character
    a_idx_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> !i_q_status.empty)
        else $error("character index advanced without a queued command");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_status.empty |-> (r_idx <= i_head.last_idx))
        else $error("character index beyond command length");

endmodule

@@ rtl/core/base64_stream_encoder.sv @@
// base64_stream_encoder: top level, front classifier, command queue and
// character back end; uses b64e_pkg, b64e_front, b64e_queue, b64e_back
//
// usage:
//   input channel  i_valid / o_stall carries one raw byte and an end flag
//   output channel o_valid / i_stall carries one ascii base64 character
//   with o_final_char set on the last character of the message
//   each byte becomes a command of one to four characters in a short queue
//   an accepted byte is written to a queue entry, and its first character
//   then goes to the output register, when the queue and output are clear
//   throughput: one character per cycle while the receiver does not stall; a
//   byte yields one or two characters in mid message, up to four on a message
//   end; the single output register port sets that rate, and the queue of
//   QUEUE_DEPTH commands lets bytes be taken in back to back while characters
//   drain
//   reset: synchronous, active low; empties the queue and the output and
//   starts a new group
//   receiver stall holds the output character; the queue fills and then
//   o_stall rises until characters drain
module base64_stream_encoder import b64e_pkg::*; #(
    parameter int QUEUE_DEPTH = 2  // two or more
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_message,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_final_char
);

    t_cmd      push_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;
    logic      push;
    logic      pop;

    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_q_status       (q_status),
        .o_stall          (o_stall),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    b64e_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_cmd),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_char   (o_out_char),
        .o_final_char (o_final_char)
    );

endmodule

@@ test/base64_stream_encoder_check.sv @@
// base64_stream_encoder_check: watches both channels of the encoder, predicts
// the base64 characters of every accepted byte and compares them in order
// depends on b64e_pkg for the phase encoding and the pad character
`timescale 1ns / 100ps

module base64_stream_encoder_check import b64e_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_message,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [CHAR_W-1:0] i_out_char,
    input  logic              i_final_char,
    input  logic              i_end_check,
    output int                o_fail_count,
    output int                o_pending
);

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_b64_char;

    t_b64_char   expected_chars[$];
    t_phase      group_pos;
    logic [3:0]  residue;
    int          mismatch_count;
    bit          leftover_counted;
    t_b64_char   oldest;

    function automatic logic [CHAR_W-1:0] b64_symbol(input logic [5:0] v);
        return B64_ALPHABET[8*(63 - int'(v)) +: CHAR_W];
    endfunction

    task automatic push_char(input logic [CHAR_W-1:0] code, input logic last);
        t_b64_char c;
        c.code = code;
        c.last = last;
        expected_chars = {expected_chars, c};
    endtask

    // characters completed by one byte, plus flush and padding on the message end
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        case (group_pos)
            PH_SECOND: begin
                push_char(b64_symbol({residue[1:0], b[7:4]}), 1'b0);
                residue   = b[3:0];
                group_pos = PH_THIRD;
                if (eom) begin
                    push_char(b64_symbol({b[3:0], 2'b00}), 1'b0);
                    push_char(PAD_CHAR, 1'b1);
                end
            end
            PH_THIRD: begin
                push_char(b64_symbol({residue, b[7:6]}), 1'b0);
                push_char(b64_symbol(b[5:0]), eom);
                residue   = 4'd0;
                group_pos = PH_FIRST;
            end
            default: begin
                push_char(b64_symbol(b[7:2]), 1'b0);
                residue   = {2'b00, b[1:0]};
                group_pos = PH_SECOND;
                if (eom) begin
                    push_char(b64_symbol({b[1:0], 4'd0}), 1'b0);
                    push_char(PAD_CHAR, 1'b0);
                    push_char(PAD_CHAR, 1'b1);
                end
            end
        endcase
        if (eom) begin
            group_pos = PH_FIRST;
            residue   = 4'd0;
        end
    endtask

    task automatic note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    initial begin
        group_pos        = PH_FIRST;
        residue          = 4'd0;
        mismatch_count   = 0;
        leftover_counted = 1'b0;
        o_fail_count     = 0;
        o_pending        = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            group_pos = PH_FIRST;
            residue   = 4'd0;
            expected_chars.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                encode_byte(i_data_byte, i_end_of_message);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    note_failure($sformatf("unexpected char %0d final %0b",
                                           i_out_char, i_final_char));
                end else begin
                    oldest = expected_chars.pop_front();
                    if (i_out_char !== oldest.code || i_final_char !== oldest.last) begin
                        note_failure($sformatf(
                            "mismatch: expected char %0d final %0b, got char %0d final %0b",
                            oldest.code, oldest.last, i_out_char, i_final_char));
                    end
                end
            end
            // characters still owed when the run ends
            if (i_end_check && !leftover_counted) begin
                leftover_counted = 1'b1;
                if (expected_chars.size() != 0) begin
                    note_failure($sformatf("%0d chars never arrived",
                                           expected_chars.size()));
                    mismatch_count += expected_chars.size() - 1;
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_chars.size();
    end

endmodule

@@ test/base64_stream_encoder_test.sv @@
// base64_stream_encoder_test: drives raw message bytes into the encoder with
// random idling on both sides and reports the verdict
// depends on b64e_pkg, base64_stream_encoder and base64_stream_encoder_check
`timescale 1ns / 100ps

module base64_stream_encoder_test import b64e_pkg::*;;

    localparam int ITEM_TARGET = 450;
    localparam int CALM_START  = 390;
    localparam int HOLD_START  = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 300000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_data_byte;
    logic              i_end_of_message;
    logic              o_valid;
    logic              i_stall;
    logic [CHAR_W-1:0] o_out_char;
    logic              o_final_char;
    logic              end_check;
    int                fail_count;
    int                pending;

    int  items_sent;
    int  cycle_count;
    int  msg_len;
    bit  calm;
    bit  steady;
    bit  hold_request;

    base64_stream_encoder uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_char       (o_out_char),
        .o_final_char     (o_final_char)
    );

    base64_stream_encoder_check checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out_char       (o_out_char),
        .i_final_char     (o_final_char),
        .i_end_check      (end_check),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offers one byte, waits for the edge that takes it and, unless calm or steady, may idle at random
    task automatic put_byte(input logic [7:0] b, input logic eom);
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        if (!calm && !steady && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic send_random_message(input int len);
        for (int k = 0; k < len; k++) begin
            put_byte(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    // receiver side: stall bursts, one long hold on request, none when calm
    initial begin
        int hold_count;
        hold_request = 1'b0;
        forever begin
            if (hold_request) begin
                i_stall <= 1'b1;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
                    @(posedge i_clk);
                end
                hold_request = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        items_sent        = 0;
        calm              = 1'b0;
        steady            = 1'b0;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_data_byte      <= 8'd0;
        i_end_of_message <= 1'b0;
        end_check        <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-, two- and three-byte messages at the byte extremes
        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b1);
        put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b0); put_byte(8'hFF, 1'b1);
        put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b0); put_byte(8'hFF, 1'b0); put_byte(8'hFF, 1'b1);
        // all plus signs, then a plain text group
        put_byte(8'hFB, 1'b0); put_byte(8'hEF, 1'b0); put_byte(8'hBE, 1'b1);
        put_byte(8'h4D, 1'b0); put_byte(8'h61, 1'b0); put_byte(8'h6E, 1'b1);
        // four bytes: a full group followed by a lone byte flush
        put_byte(8'hAA, 1'b0); put_byte(8'h55, 1'b0);
        put_byte(8'hAA, 1'b0); put_byte(8'h55, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= HOLD_START && items_sent < HOLD_START + 40) begin
                // receiver holds off while bytes keep coming
                steady       = 1'b1;
                hold_request = 1'b1;
                send_random_message(40);
            end else begin
                calm    = items_sent >= CALM_START;
                steady  = $urandom_range(0, 4) == 0;
                msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                      : $urandom_range(1, 12);
                send_random_message(msg_len);
            end
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (3) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/b64e_pkg.sv
rtl/core/b64e_front.sv
rtl/core/b64e_queue.sv
rtl/core/b64e_back.sv
rtl/core/base64_stream_encoder.sv
test/base64_stream_encoder_check.sv
test/base64_stream_encoder_test.sv
